[hdl/csi_pkg.sv]
// Shared types and constants for the cardinal spline interpolator.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package csi_pkg;

  // Opcode of an input item
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } csi_op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_START_TIME  = 2'd0,
    CFG_RATE        = 2'd1,
    CFG_TIGHTNESS   = 2'd2,
    CFG_POINT_COUNT = 2'd3
  } csi_cfg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DEC,
    ST_READ,
    ST_CALC,
    ST_FIN,
    ST_LAST
  } csi_state_e;

  // Lane arithmetic steps, issued in this order
  typedef enum logic [2:0] {
    STEP_T1   = 3'd0,
    STEP_T2   = 3'd1,
    STEP_P1H1 = 3'd2,
    STEP_P2H2 = 3'd3,
    STEP_T1L  = 3'd4,
    STEP_T1H  = 3'd5,
    STEP_T2L  = 3'd6,
    STEP_T2H  = 3'd7
  } csi_step_e;

  // Where the merge stage takes the position from
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_POINT,
    SRC_LANES
  } csi_src_e;

  localparam int unsigned FracW  = 24;
  localparam int unsigned HermW  = 26;
  localparam int unsigned TanW   = 41;
  localparam int unsigned AccW   = 64;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  point_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0] time_ms;
  } csi_in_t;

  typedef struct packed {
    logic        finished;
    logic        has_value;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } csi_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } csi_point_t;

  // Hermite basis weights, Q.24
  typedef struct packed {
    logic signed [HermW-1:0] h1;
    logic signed [HermW-1:0] h2;
    logic signed [HermW-1:0] h3;
    logic signed [HermW-1:0] h4;
  } csi_herm_t;

  // Control from the sequencer to each lane
  typedef struct packed {
    logic      load_p;
    logic [1:0] p_sel;
    logic      calc;
    csi_step_e step;
  } csi_lane_ctl_t;

  // Control from the sequencer to the merge stage
  typedef struct packed {
    logic     emit;
    logic     finished;
    csi_src_e src;
  } csi_merge_ctl_t;

endpackage

`default_nettype wire

[hdl/csi_lane.sv]
// One coordinate lane: holds four control-point values and evaluates the
// Hermite sum with a single shared multiplier. Depends on csi_pkg.
`default_nettype none

module csi_lane (
  input  wire logic                        clk_i,
  input  wire csi_pkg::csi_lane_ctl_t      ctl_i,
  input  wire logic signed [31:0]          rdata_i,
  input  wire logic signed [15:0]          tight_i,
  input  wire csi_pkg::csi_herm_t          herm_i,
  output logic signed [csi_pkg::AccW-1:0]  acc_o
);

  logic signed [31:0]               p_q [4];
  logic signed [csi_pkg::TanW-1:0]  t1_q, t2_q;
  logic signed [csi_pkg::AccW-1:0]  acc_q;
  logic signed [32:0]               a_op;
  logic signed [csi_pkg::HermW-1:0] b_op;
  logic signed [58:0]               prod;

  // Select multiplier operands for the current step
  always_comb begin
    a_op = '0;
    b_op = '0;
    unique case (ctl_i.step)
      csi_pkg::STEP_T1: begin
        a_op = 33'(p_q[2]) - 33'(p_q[0]);
        b_op = csi_pkg::HermW'(tight_i);
      end
      csi_pkg::STEP_T2: begin
        a_op = 33'(p_q[3]) - 33'(p_q[1]);
        b_op = csi_pkg::HermW'(tight_i);
      end
      csi_pkg::STEP_P1H1: begin
        a_op = 33'(p_q[1]);
        b_op = herm_i.h1;
      end
      csi_pkg::STEP_P2H2: begin
        a_op = 33'(p_q[2]);
        b_op = herm_i.h2;
      end
      csi_pkg::STEP_T1L: begin
        a_op = $signed({9'b0, t1_q[23:0]});
        b_op = herm_i.h3;
      end
      csi_pkg::STEP_T1H: begin
        a_op = 33'($signed(t1_q[csi_pkg::TanW-1:24]));
        b_op = herm_i.h3;
      end
      csi_pkg::STEP_T2L: begin
        a_op = $signed({9'b0, t2_q[23:0]});
        b_op = herm_i.h4;
      end
      csi_pkg::STEP_T2H: begin
        a_op = 33'($signed(t2_q[csi_pkg::TanW-1:24]));
        b_op = herm_i.h4;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
    prod = 59'(a_op) * 59'(b_op);
  end

  // Load points, then run one multiply per step into a tangent or the accumulator
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_p) begin
      p_q[ctl_i.p_sel] <= rdata_i;
    end
    if (ctl_i.calc) begin
      unique case (ctl_i.step)
        csi_pkg::STEP_T1:   t1_q  <= csi_pkg::TanW'(prod >>> 8);
        csi_pkg::STEP_T2:   t2_q  <= csi_pkg::TanW'(prod >>> 8);
        csi_pkg::STEP_P1H1: acc_q <= csi_pkg::AccW'(prod);
        csi_pkg::STEP_T1H,
        csi_pkg::STEP_T2H:  acc_q <= acc_q + (csi_pkg::AccW'(prod) <<< 24);
        default:            acc_q <= acc_q + csi_pkg::AccW'(prod);
      endcase
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

[hdl/csi_merge.sv]
// Merge stage: saturates the three lane sums or passes a stored point, and
// holds the result register and its one-cycle done pulse. Depends on csi_pkg.
`default_nettype none

module csi_merge (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire csi_pkg::csi_merge_ctl_t     ctl_i,
  input  wire csi_pkg::csi_point_t         point_i,
  input  wire logic signed [csi_pkg::AccW-1:0] acc_x_i,
  input  wire logic signed [csi_pkg::AccW-1:0] acc_y_i,
  input  wire logic signed [csi_pkg::AccW-1:0] acc_z_i,
  output logic                             done_o,
  output csi_pkg::csi_out_t                res_o
);

  logic              done_q;
  csi_pkg::csi_out_t res_q, res_d;

  // Shift down by the fraction and clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat_q24(input logic signed [63:0] acc);
    logic signed [31:0] r;
    if (acc[63:55] == {9{acc[55]}}) begin
      r = acc[55:24];
    end else if (acc[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // Pick the position source
  always_comb begin
    res_d          = '0;
    res_d.finished = ctl_i.finished;
    unique case (ctl_i.src)
      csi_pkg::SRC_POINT: begin
        res_d.has_value = 1'b1;
        res_d.out_x     = point_i.x;
        res_d.out_y     = point_i.y;
        res_d.out_z     = point_i.z;
      end
      csi_pkg::SRC_LANES: begin
        res_d.has_value = 1'b1;
        res_d.out_x     = sat_q24(acc_x_i);
        res_d.out_y     = sat_q24(acc_y_i);
        res_d.out_z     = sat_q24(acc_z_i);
      end
      default: res_d.has_value = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

[hdl/cardinal_spline_interpolator.sv]
// Cardinal spline interpolator: a write item (start with opcode 0) stores a
// control point. An evaluate item keeps busy high on a curve segment for a
// 32x32 time multiply, a segment decode, reads through the single read port
// of the point memory, eight multiply steps in each of the three coordinate
// lanes and a merge state; when the path is finished or its single point has
// been reached, for the multiply, decode and a read of that point; and for
// the multiply and decode alone when the table is empty or the start time
// has not passed with a single point. The result is shown for one cycle with
// done_o right after busy falls and cannot be held off; a new item may be
// started in that same cycle. Depends on csi_pkg, csi_lane and csi_merge.
`default_nettype none

module cardinal_spline_interpolator #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire csi_pkg::csi_in_t  in_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i,
  output logic                   done_o,
  output csi_pkg::csi_out_t      res_o
);

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);

  csi_pkg::csi_state_e state_q, state_d;

  logic [31:0]        start_q, rate_q;
  logic signed [15:0] tight_q;
  logic [4:0]         count_q;

  logic [31:0] elapsed_q;
  logic        later_q;
  logic [NW-1:0] n_q;
  logic [63:0] prod_q;
  logic [IW-1:0] idx_q [4];
  logic [23:0] u2_q, u3_q;
  csi_pkg::csi_herm_t herm_q;
  logic [2:0]  cnt_q;
  csi_pkg::csi_step_e step_q;

  csi_pkg::csi_point_t mem_q [MAX_POINTS];
  csi_pkg::csi_point_t rdata_q;
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  csi_pkg::csi_lane_ctl_t  lane_ctl;
  csi_pkg::csi_merge_ctl_t merge_ctl;

  logic        accept, wr_en;
  logic [NW-1:0] n_d, n_m1, seg_lo;
  logic [NW:0]   i3_sum;
  logic        seg_last;
  logic [23:0] u;
  logic [47:0] u2_full, u3_full;
  logic signed [26:0] s_u, s_u2, s_u3;

  logic signed [csi_pkg::AccW-1:0] acc_x, acc_y, acc_z;

  assign accept      = start && !busy;
  assign busy        = (state_q != csi_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign wr_en       = accept && (in_i.opcode == csi_pkg::OP_WRITE)
                       && (32'(in_i.point_index) < 32'(MAX_POINTS));

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      rate_q  <= '0;
      tight_q <= 16'sd128;
      count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        csi_pkg::CFG_START_TIME:  start_q <= cfg_data_i;
        csi_pkg::CFG_RATE:        rate_q  <= cfg_data_i;
        csi_pkg::CFG_TIGHTNESS:   tight_q <= cfg_data_i[15:0];
        csi_pkg::CFG_POINT_COUNT: count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Point memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[IW'(in_i.point_index)] <= '{x: in_i.point_x, y: in_i.point_y, z: in_i.point_z};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Segment decode and fraction powers
  always_comb begin
    n_d      = (32'(count_q) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(count_q);
    n_m1     = n_q - NW'(1);
    seg_last = (prod_q[63:24] >= 40'(n_m1));
    seg_lo   = prod_q[24 +: NW];
    i3_sum   = (NW + 1)'(seg_lo) + (NW + 1)'(2);
    if (i3_sum >= (NW + 1)'(n_q)) begin
      i3_sum = i3_sum - (NW + 1)'(n_q);
    end
    u       = prod_q[23:0];
    u2_full = 48'(u) * 48'(u);
    u3_full = 48'(u2_q) * 48'(u);
    s_u     = $signed({3'b0, u});
    s_u2    = $signed({3'b0, u2_q});
    s_u3    = $signed({3'b0, u3_q});
  end

  // Datapath registers per state
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      csi_pkg::ST_IDLE: begin
        elapsed_q <= in_i.time_ms - start_q;
        later_q   <= (in_i.time_ms > start_q);
        n_q       <= n_d;
      end
      csi_pkg::ST_MUL: prod_q <= 64'(elapsed_q) * 64'(rate_q);
      csi_pkg::ST_DEC: begin
        idx_q[1] <= IW'(seg_lo);
        idx_q[0] <= (seg_lo == '0) ? IW'(n_m1) : IW'(seg_lo - NW'(1));
        idx_q[2] <= IW'(seg_lo + NW'(1));
        idx_q[3] <= IW'(i3_sum);
        u2_q     <= u2_full[47:24];
      end
      csi_pkg::ST_READ: begin
        if (cnt_q == 3'd0) begin
          u3_q <= u3_full[47:24];
        end
        if (cnt_q == 3'd1) begin
          herm_q.h1 <= csi_pkg::HermW'(2 * s_u3 - 3 * s_u2 + 27'sd16777216);
          herm_q.h2 <= csi_pkg::HermW'(3 * s_u2 - 2 * s_u3);
          herm_q.h3 <= csi_pkg::HermW'(s_u3 - 2 * s_u2 + s_u);
          herm_q.h4 <= csi_pkg::HermW'(s_u3 - s_u2);
        end
      end
      default: ;
    endcase
  end

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csi_pkg::ST_IDLE;
      cnt_q   <= '0;
      step_q  <= csi_pkg::STEP_T1;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_q == csi_pkg::ST_READ) ? cnt_q + 3'd1 : 3'd0;
      step_q  <= (state_q == csi_pkg::ST_CALC) ? csi_pkg::csi_step_e'(step_q + 3'd1)
                                               : csi_pkg::STEP_T1;
    end
  end

  // Next state, memory reads, lane and merge control
  always_comb begin
    state_d   = state_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    lane_ctl  = '{load_p: 1'b0, p_sel: 2'd0, calc: 1'b0, step: step_q};
    merge_ctl = '{emit: 1'b0, finished: 1'b0, src: csi_pkg::SRC_NONE};
    unique case (state_q)
      csi_pkg::ST_IDLE: begin
        if (accept && (in_i.opcode == csi_pkg::OP_EVAL)) begin
          state_d = csi_pkg::ST_MUL;
        end
      end
      csi_pkg::ST_MUL: state_d = csi_pkg::ST_DEC;
      csi_pkg::ST_DEC: begin
        priority if (n_q == '0) begin
          merge_ctl = '{emit: 1'b1, finished: 1'b1, src: csi_pkg::SRC_NONE};
          state_d   = csi_pkg::ST_IDLE;
        end else if (n_q == NW'(1)) begin
          if (later_q) begin
            rd_en   = 1'b1;
            state_d = csi_pkg::ST_LAST;
          end else begin
            merge_ctl = '{emit: 1'b1, finished: 1'b0, src: csi_pkg::SRC_NONE};
            state_d   = csi_pkg::ST_IDLE;
          end
        end else if (seg_last) begin
          rd_en   = 1'b1;
          rd_addr = IW'(n_m1);
          state_d = csi_pkg::ST_LAST;
        end else begin
          state_d = csi_pkg::ST_READ;
        end
      end
      csi_pkg::ST_READ: begin
        if (cnt_q < 3'd4) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[cnt_q[1:0]];
        end
        if (cnt_q != 3'd0) begin
          lane_ctl.load_p = 1'b1;
          lane_ctl.p_sel  = 2'(cnt_q - 3'd1);
        end
        if (cnt_q == 3'd4) begin
          state_d = csi_pkg::ST_CALC;
        end
      end
      csi_pkg::ST_CALC: begin
        lane_ctl.calc = 1'b1;
        if (step_q == csi_pkg::STEP_T2H) begin
          state_d = csi_pkg::ST_FIN;
        end
      end
      csi_pkg::ST_FIN: begin
        merge_ctl = '{emit: 1'b1, finished: 1'b0, src: csi_pkg::SRC_LANES};
        state_d   = csi_pkg::ST_IDLE;
      end
      csi_pkg::ST_LAST: begin
        merge_ctl = '{emit: 1'b1, finished: 1'b1, src: csi_pkg::SRC_POINT};
        state_d   = csi_pkg::ST_IDLE;
      end
      default: state_d = csi_pkg::ST_IDLE;
    endcase
  end

  csi_lane u_lane_x (
    .clk_i  (clk_i),
    .ctl_i  (lane_ctl),
    .rdata_i(rdata_q.x),
    .tight_i(tight_q),
    .herm_i (herm_q),
    .acc_o  (acc_x)
  );

  csi_lane u_lane_y (
    .clk_i  (clk_i),
    .ctl_i  (lane_ctl),
    .rdata_i(rdata_q.y),
    .tight_i(tight_q),
    .herm_i (herm_q),
    .acc_o  (acc_y)
  );

  csi_lane u_lane_z (
    .clk_i  (clk_i),
    .ctl_i  (lane_ctl),
    .rdata_i(rdata_q.z),
    .tight_i(tight_q),
    .herm_i (herm_q),
    .acc_o  (acc_z)
  );

  csi_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (merge_ctl),
    .point_i(rdata_q),
    .acc_x_i(acc_x),
    .acc_y_i(acc_y),
    .acc_z_i(acc_z),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire
